FILE: rtl/ffha_pkg.sv
// Shared types and codes of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned ADDR_W = 32;

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] byte_count;
    logic [3:0]        align_log2;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] grant_addr;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
  } seg_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } cfg_wr_t;

endpackage

FILE: rtl/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ffha_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ffha_ctrl.sv
// Sequencer that scans, shifts and merges the free-segment table held in RAM.
module ffha_ctrl #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ffha_pkg::req_t                     in_data,
  input  ffha_pkg::cfg_wr_t                  cfg,
  output logic                               idle,
  output logic                               done,
  output ffha_pkg::rsp_t                     rsp,
  input  logic                               take,
  output logic                               ram_we,
  output logic [$clog2(MAX_SEGMENTS)-1:0]    ram_waddr,
  output ffha_pkg::seg_t                     ram_wdata,
  output logic [$clog2(MAX_SEGMENTS)-1:0]    ram_raddr,
  input  ffha_pkg::seg_t                     ram_rdata
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [14:0] {
    S_INIT    = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_A_RD    = 15'b000000000000100,
    S_A_CHK   = 15'b000000000001000,
    S_RM_RD   = 15'b000000000010000,
    S_RM_WR   = 15'b000000000100000,
    S_IN_RD   = 15'b000000001000000,
    S_IN_CHK  = 15'b000000010000000,
    S_UP_RD   = 15'b000000100000000,
    S_UP_WR   = 15'b000001000000000,
    S_MG_INIT = 15'b000010000000000,
    S_MG_P    = 15'b000100000000000,
    S_MG_RD   = 15'b001000000000000,
    S_MG_CHK  = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  typedef enum logic [2:0] {
    RET_DONE = 3'b001,
    RET_INS  = 3'b010,
    RET_MRG  = 3'b100
  } ret_t;

  state_t            state;
  ret_t              ret;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     j;
  logic              is_free;
  logic [ADDR_W-1:0] bytes;
  logic [3:0]        alog;
  logic [ADDR_W-1:0] ins_start;
  logic [ADDR_W-1:0] ins_len;
  logic [ADDR_W-1:0] grant;
  logic [1:0]        status;
  seg_t              prev;

  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] adj;
  logic [ADDR_W:0]   need;
  logic              fit;
  logic [ADDR_W-1:0] left;
  logic [ADDR_W:0]   prev_end;
  logic              adjacent;
  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] sat;
  logic [CW-1:0]     j_inc;
  logic [CW-1:0]     j_dec;
  logic [CW-1:0]     idx_dec;

  always_comb begin
    mask     = ~({ADDR_W{1'b1}} << alog);
    adj      = (ADDR_W'(0) - ram_rdata.start) & mask;
    need     = {1'b0, bytes} + {1'b0, adj};
    fit      = {1'b0, ram_rdata.length} >= need;
    left     = ram_rdata.length - need[ADDR_W-1:0];
    prev_end = {1'b0, prev.start} + {1'b0, prev.length};
    adjacent = prev_end == {1'b0, ram_rdata.start};
    sum      = {1'b0, prev.length} + {1'b0, ram_rdata.length};
    sat      = sum[ADDR_W] ? {ADDR_W{1'b1}} : sum[ADDR_W-1:0];
    j_inc    = j + CW'(1);
    j_dec    = j - CW'(1);
    idx_dec  = idx - CW'(1);
  end

  // Read address and write port, one access of each kind per cycle at most.
  always_comb begin
    ram_raddr = idx[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = '{start: ins_start, length: ins_len};
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_we    = cfg.wr;
        ram_waddr = '0;
        ram_wdata = '{start: cfg.base, length: cfg.size};
      end
      S_RM_RD:   ram_raddr = j_inc[AW-1:0];
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_IN_CHK: begin
        ram_we    = ram_rdata.start == ins_start;
        ram_wdata = '{start: ram_rdata.start, length: ins_len};
      end
      S_UP_RD: begin
        ram_raddr = j_dec[AW-1:0];
        ram_we    = !(j > idx);
      end
      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_MG_INIT: ram_raddr = '0;
      S_MG_CHK: begin
        ram_we    = adjacent;
        ram_waddr = idx_dec[AW-1:0];
        ram_wdata = '{start: prev.start, length: sat};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= CW'(1);
    end else begin
      unique case (state)
        S_INIT: begin
          cnt   <= CW'(1);
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg.wr) begin
            cnt <= CW'(1);
          end
          if (in_valid) begin
            is_free <= in_data.req_type == REQ_FREE;
            bytes   <= in_data.byte_count;
            alog    <= in_data.align_log2;
            grant   <= '0;
            status  <= ST_DONE;
            idx     <= '0;
            if (in_data.req_type == REQ_ALLOC) begin
              state <= S_A_RD;
            end else if (in_data.free_addr == '0 || in_data.byte_count == '0) begin
              state <= S_DONE;
            end else begin
              ins_start <= in_data.free_addr;
              ins_len   <= in_data.byte_count;
              state     <= S_IN_RD;
            end
          end
        end
        S_A_RD: begin
          if (idx >= cnt) begin
            status <= ST_NO_FIT;
            state  <= S_DONE;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (fit) begin
            grant     <= ram_rdata.start + adj;
            ins_start <= ram_rdata.start + adj + bytes;
            ins_len   <= left;
            j         <= idx;
            ret       <= (left != '0) ? RET_INS : RET_DONE;
            state     <= S_RM_RD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_A_RD;
          end
        end
        S_RM_RD: begin
          if (j_inc < cnt) begin
            state <= S_RM_WR;
          end else begin
            cnt <= cnt - CW'(1);
            unique case (ret)
              RET_INS: begin
                idx   <= '0;
                state <= S_IN_RD;
              end
              RET_MRG: state <= S_MG_RD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_RM_WR: begin
          j     <= j_inc;
          state <= S_RM_RD;
        end
        S_IN_RD: begin
          if (idx >= cnt) begin
            if (cnt >= CW'(MAX_SEGMENTS)) begin
              status <= ST_FULL;
              state  <= S_DONE;
            end else begin
              j     <= cnt;
              state <= S_UP_RD;
            end
          end else begin
            state <= S_IN_CHK;
          end
        end
        S_IN_CHK: begin
          if (ram_rdata.start < ins_start) begin
            idx   <= idx + CW'(1);
            state <= S_IN_RD;
          end else if (ram_rdata.start == ins_start) begin
            state <= is_free ? S_MG_INIT : S_DONE;
          end else if (cnt >= CW'(MAX_SEGMENTS)) begin
            status <= ST_FULL;
            state  <= S_DONE;
          end else begin
            j     <= cnt;
            state <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          if (j > idx) begin
            state <= S_UP_WR;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= is_free ? S_MG_INIT : S_DONE;
          end
        end
        S_UP_WR: begin
          j     <= j_dec;
          state <= S_UP_RD;
        end
        S_MG_INIT: state <= S_MG_P;
        S_MG_P: begin
          prev  <= ram_rdata;
          idx   <= CW'(1);
          state <= S_MG_RD;
        end
        S_MG_RD: begin
          state <= (idx >= cnt) ? S_DONE : S_MG_CHK;
        end
        S_MG_CHK: begin
          if (adjacent) begin
            prev.length <= sat;
            j           <= idx;
            ret         <= RET_MRG;
            state       <= S_RM_RD;
          end else begin
            prev  <= ram_rdata;
            idx   <= idx + CW'(1);
            state <= S_MG_RD;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  assign idle     = state == S_IDLE;
  assign in_stall = state != S_IDLE;
  assign done     = state == S_DONE;
  assign rsp      = '{grant_addr: grant, status: status};

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SEGMENTS)) else $error("segment count beyond table depth");
  a_full_only_free: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> is_free) else $error("table full on allocate");
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_DONE |-> grant == '0) else $error("grant on failed request");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE) else $error("item accepted but idle");

endmodule

FILE: rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator: one heap region, free segments held in address order in a RAM.
// Each item is an allocate or a free request and yields exactly one result item
// {grant_addr, status}. An allocate walks the table from the lowest address, takes the
// first segment that holds the byte count plus alignment padding, then closes the gap by
// shifting the later entries down and, when a tail is left, inserts it (scan plus a shift
// of the later entries up). A free with a nonzero address and byte count inserts the
// segment the same way and then runs a merge pass over the whole table, with a shift for
// every merge. The table RAM has a single read port. After reset the block writes the
// first table entry before it accepts items. Writing heap_base or heap_size (only while
// idle) resets the table to one segment covering the heap. The result register lets the
// next item be taken while a result still waits downstream.
module first_fit_heap_allocator_unit #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  ffha_pkg::req_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ffha_pkg::rsp_t                        out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]           cfg_data
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);

  logic [ADDR_W-1:0] heap_base;
  logic [ADDR_W-1:0] heap_size;
  cfg_wr_t           cfg;
  logic              idle;
  logic              done;
  logic              take;
  rsp_t              rsp;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  seg_t              ram_wdata;
  logic [AW-1:0]     ram_raddr;
  seg_t              ram_rdata;

  // Configuration: take writes only while the sequencer idles.
  assign cfg_ready = idle;

  always_comb begin
    cfg.wr   = cfg_valid && cfg_ready;
    cfg.base = (cfg_index == CFG_HEAP_BASE) ? cfg_data : heap_base;
    cfg.size = (cfg_index == CFG_HEAP_SIZE) ? cfg_data : heap_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      heap_size <= '0;
    end else if (cfg.wr) begin
      heap_base <= cfg.base;
      heap_size <= cfg.size;
    end
  end

  ffha_ram #(
    .WIDTH($bits(seg_t)),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffha_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .idle     (idle),
    .done     (done),
    .rsp      (rsp),
    .take     (take),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  // Result register: load a finished item when the slot is empty or draining.
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && take) begin
      out_data <= rsp;
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the first-fit heap allocator unit.
module tb;
  import ffha_pkg::*;

  localparam int unsigned SEGS      = 64;
  localparam int unsigned CYC_LIMIT = 8000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  req_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rsp_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;

  first_fit_heap_allocator_unit #(.MAX_SEGMENTS(SEGS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the free-segment table and the heap registers.
  logic [31:0] heap_lo, heap_sz;
  logic [31:0] seg_lo [SEGS];
  logic [31:0] seg_len[SEGS];
  int unsigned seg_n;

  req_t        pending_q[$];     // items waiting to be driven
  rsp_t        grant_expect_q[$]; // results still owed by the block
  bit          idling_on = 1'b1;
  int unsigned err_cnt = 0;
  int unsigned items_sent = 0, grants_seen = 0, full_seen = 0, nofit_seen = 0;
  int unsigned cyc = 0;

  function automatic void table_restart();
    for (int i = 0; i < SEGS; i++) begin
      seg_lo[i]  = '0;
      seg_len[i] = '0;
    end
    seg_lo[0]  = heap_lo;
    seg_len[0] = heap_sz;
    seg_n      = 1;
  endfunction

  function automatic void seg_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < seg_n; i++) begin
      seg_lo[i]  = seg_lo[i+1];
      seg_len[i] = seg_len[i+1];
    end
    if (seg_n > 0) begin
      seg_n--;
      seg_lo[seg_n]  = '0;
      seg_len[seg_n] = '0;
    end
  endfunction

  // Insert in address order, or overwrite a segment with the same start.
  function automatic bit seg_place(logic [31:0] s, logic [31:0] l);
    int unsigned pos;
    pos = 0;
    while (pos < seg_n && seg_lo[pos] < s) pos++;
    if (pos < seg_n && seg_lo[pos] == s) begin
      seg_len[pos] = l;
      return 1'b1;
    end
    if (seg_n >= SEGS) return 1'b0;
    for (int unsigned i = seg_n; i > pos; i--) begin
      seg_lo[i]  = seg_lo[i-1];
      seg_len[i] = seg_len[i-1];
    end
    seg_lo[pos]  = s;
    seg_len[pos] = l;
    seg_n++;
    return 1'b1;
  endfunction

  function automatic void seg_coalesce();
    int unsigned i;
    logic [32:0] tail_end, sum;
    i = 1;
    while (i < seg_n) begin
      tail_end = {1'b0, seg_lo[i-1]} + {1'b0, seg_len[i-1]};
      if (tail_end == {1'b0, seg_lo[i]}) begin
        sum = {1'b0, seg_len[i-1]} + {1'b0, seg_len[i]};
        seg_len[i-1] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        seg_drop(i);
      end else begin
        i++;
      end
    end
  endfunction

  // Apply one request to the shadow table and return the result it owes.
  function automatic rsp_t predict_grant(req_t r);
    rsp_t        o;
    logic [31:0] msk, pad, lft;
    logic [32:0] need;
    bit          hit;
    o   = '0;
    hit = 1'b0;
    if (r.req_type == REQ_ALLOC) begin
      o.status = ST_NO_FIT;
      msk = (32'd1 << r.align_log2) - 32'd1;
      for (int unsigned i = 0; i < seg_n && !hit; i++) begin
        pad  = (32'd0 - seg_lo[i]) & msk;
        need = {1'b0, r.byte_count} + {1'b0, pad};
        if ({1'b0, seg_len[i]} >= need) begin
          lft          = seg_len[i] - need[31:0];
          o.grant_addr = seg_lo[i] + pad;
          seg_drop(i);
          if (lft != 0) void'(seg_place(o.grant_addr + r.byte_count, lft));
          o.status = ST_DONE;
          hit      = 1'b1;
        end
      end
    end else if (r.free_addr != 0 && r.byte_count != 0) begin
      if (seg_place(r.free_addr, r.byte_count)) seg_coalesce();
      else o.status = ST_FULL;
    end
    return o;
  endfunction

  // Driver: hold the item while stalled, advance on acceptance, idle in bursts.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        grant_expect_q.push_back(predict_grant(in_data));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (idling_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result against the oldest expectation.
  int unsigned hold_cnt = 0;
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_expect_q.size() == 0) begin
          $error("result item with no expectation: grant_addr %h status %0d",
                 out_data.grant_addr, out_data.status);
          err_cnt++;
        end else begin
          want = grant_expect_q.pop_front();
          if (out_data.grant_addr !== want.grant_addr) begin
            $error("grant_addr expected %h got %h", want.grant_addr, out_data.grant_addr);
            err_cnt++;
          end
          if (out_data.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_data.status);
            err_cnt++;
          end
          if (want.status == ST_DONE && want.grant_addr != 0) grants_seen++;
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_NO_FIT) nofit_seen++;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idling_on && $urandom_range(0, 9) == 0) hold_cnt = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Write one register; the block is idle whenever this is called.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_HEAP_BASE) heap_lo = val;
    else heap_sz = val;
    table_restart();
  endtask

  // Hold until the block has returned every owed result.
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || grant_expect_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t mk_req(logic rt, logic [31:0] n, logic [3:0] al, logic [31:0] a);
    req_t r;
    r.req_type   = rt;
    r.byte_count = n;
    r.align_log2 = al;
    r.free_addr  = a;
    return r;
  endfunction

  // Mostly allocations and frees at addresses in and around the heap; the rest is raw noise.
  function automatic req_t rand_req(logic [31:0] lo, logic [31:0] span, int unsigned big);
    int unsigned pick;
    logic [31:0] off;
    pick = $urandom_range(0, 15);
    off  = (span == 0) ? 32'd0 : ($urandom % span);
    if (pick == 0)
      return mk_req(1'($urandom_range(0, 1)), $urandom, 4'($urandom_range(0, 12)), $urandom);
    if (pick < 8)
      return mk_req(REQ_ALLOC, $urandom_range(0, big),
                    ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 12))
                                                : 4'($urandom_range(0, 4)),
                    $urandom);
    return mk_req(REQ_FREE, $urandom_range(1, big), 4'($urandom_range(0, 12)),
                  lo + (off & ~32'hF));
  endfunction

  task automatic random_phase(logic [31:0] lo, logic [31:0] sz, logic [31:0] span,
                              int unsigned big, int unsigned cnt);
    write_reg(CFG_HEAP_BASE, lo);
    write_reg(CFG_HEAP_SIZE, sz);
    for (int unsigned i = 0; i < cnt; i++) pending_q.push_back(rand_req(lo, span, big));
    drain();
  endtask

  initial begin
    heap_lo = '0;
    heap_sz = '0;
    table_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty heap after reset, zero-byte allocate, null frees, extremes.
    pending_q.push_back(mk_req(REQ_ALLOC, 32'd0, 4'd0, 32'd0));
    pending_q.push_back(mk_req(REQ_ALLOC, 32'd1, 4'd0, 32'd0));
    pending_q.push_back(mk_req(REQ_FREE, 32'd16, 4'd0, 32'd0));
    pending_q.push_back(mk_req(REQ_FREE, 32'd0, 4'd0, 32'h100));
    pending_q.push_back(mk_req(REQ_FREE, 32'h100, 4'd0, 32'h100));
    pending_q.push_back(mk_req(REQ_FREE, 32'h80, 4'd0, 32'h100));   // same start: overwrite
    pending_q.push_back(mk_req(REQ_FREE, 32'h80, 4'd0, 32'h180));   // adjacent: merge
    pending_q.push_back(mk_req(REQ_ALLOC, 32'h10, 4'd12, 32'd0));
    pending_q.push_back(mk_req(REQ_ALLOC, 32'h10, 4'd3, 32'd0));
    pending_q.push_back(mk_req(REQ_FREE, 32'hFFFF_FFFF, 4'd0, 32'h1000));
    pending_q.push_back(mk_req(REQ_FREE, 32'hFFFF_FFFF, 4'd0, 32'hFFFF_FFFF));
    pending_q.push_back(mk_req(REQ_FREE, 32'h10, 4'd0, 32'hFFFF_FFF0)); // ends at 2^32, not adjacent: no merge
    pending_q.push_back(mk_req(REQ_ALLOC, 32'hFFFF_FFFF, 4'd12, 32'hFFFF_FFFF));
    pending_q.push_back(mk_req(REQ_ALLOC, 32'hFFFF_FFF0, 4'd0, 32'd0));
    pending_q.push_back(mk_req(REQ_ALLOC, 32'd0, 4'd12, 32'd0));
    drain();

    // Address wrap: heap at the top of memory, allocations run past 2^32.
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
    pending_q.push_back(mk_req(REQ_ALLOC, 32'h200, 4'd4, 32'd0));
    pending_q.push_back(mk_req(REQ_ALLOC, 32'h10, 4'd12, 32'd0));
    pending_q.push_back(mk_req(REQ_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0));
    drain();

    // Fill the table with scattered frees until it overflows.
    write_reg(CFG_HEAP_BASE, 32'h1000);
    write_reg(CFG_HEAP_SIZE, 32'h10);
    for (int unsigned i = 0; i < 70; i++)
      pending_q.push_back(mk_req(REQ_FREE, 32'h8, 4'd0, 32'h2000 + i * 32'h20));
    drain();

    random_phase(32'h1000, 32'h8000, 32'h9000, 512, 600);
    random_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4096, 350);
    random_phase(32'd0, 32'h0, 32'h4000, 256, 200);
    random_phase(32'h40, 32'h1000, 32'h1200, 96, 250);
    idling_on = 1'b0;
    random_phase(32'h10, 32'h2000, 32'h2400, 128, 400);

    $display("covered %0d items: %0d grants, %0d no-fit, %0d table-full results",
             items_sent, grants_seen, nofit_seen, full_seen);
    $display("heap settings from empty and full-range to wrapping, mismatches %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
